[hw/rtl/tcw_pkg.sv]
package tcw_pkg;

  parameter int COLUMNS_DEFAULT = 80;
  parameter int ROWS_DEFAULT = 25;

  parameter int CELL_W = 16;
  parameter int INDEX_W = 11;

  parameter logic [7:0] CH_NEWLINE = 8'h0A;
  parameter logic [7:0] CH_RETURN = 8'h0D;
  parameter logic [7:0] CH_BACKSPACE = 8'h08;
  parameter logic [7:0] CH_SPACE = 8'h20;

  parameter logic [3:0] RESET_FG = 4'hB;
  parameter logic [3:0] RESET_BG = 4'h0;
  parameter logic [CELL_W-1:0] RESET_BLANK = {RESET_BG, RESET_FG, CH_SPACE};

  parameter logic [1:0] MODE_PUT = 2'd0;
  parameter logic [1:0] MODE_CLEAR = 2'd1;
  parameter logic [1:0] MODE_READ = 2'd2;

  parameter logic CFG_FOREGROUND = 1'b0;
  parameter logic CFG_BACKGROUND = 1'b1;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CHAR,
    OP_NEWLINE,
    OP_RETURN,
    OP_BACKSPACE,
    OP_CLEAR,
    OP_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    logic [7:0] ch;
    logic [INDEX_W-1:0] index;
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CLEAR,
    ST_SCROLL,
    ST_BLANK,
    ST_EMIT
  } back_state_t;

endpackage

[hw/rtl/tcw_front.sv]
module tcw_front import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS = ROWS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [7:0]         char_code,
  input  logic [INDEX_W-1:0] cell_index,
  input  logic               hold,
  output logic               op_valid,
  input  logic               op_ready,
  output op_t                op
);

  localparam int CELL_COUNT = ROWS * COLUMNS;

  op_t        entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  op_t        classified;
  logic       push;
  logic       pop;

  always_comb begin
    classified.kind = OP_NONE;
    classified.ch = char_code;
    classified.index = cell_index;
    case (mode)
      MODE_PUT: begin
        case (char_code)
          CH_NEWLINE:   classified.kind = OP_NEWLINE;
          CH_RETURN:    classified.kind = OP_RETURN;
          CH_BACKSPACE: classified.kind = OP_BACKSPACE;
          default:      classified.kind = OP_CHAR;
        endcase
      end
      MODE_CLEAR: classified.kind = OP_CLEAR;
      MODE_READ: begin
        if (32'(cell_index) < 32'(CELL_COUNT)) begin
          classified.kind = OP_READ;
        end
      end
      default: classified.kind = OP_NONE;
    endcase
  end

  assign in_ready = (count != 2'd2) && !hold;
  assign op_valid = (count != 2'd0);
  assign op = entries[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = op_valid && op_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/tcw_back.sv]
module tcw_back import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS = ROWS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [3:0]        fg,
  input  logic [3:0]        bg,
  input  logic              op_valid,
  output logic              op_ready,
  input  op_t               op,
  output logic              init_busy,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CELL_W-1:0] cell_word,
  output logic [4:0]        cursor_row,
  output logic [6:0]        cursor_col,
  output logic [10:0]       cursor_offset
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_COPY = ADDR_W'((ROWS - 1) * COLUMNS - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  logic [CELL_W-1:0] cells [CELL_COUNT];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  back_state_t       state;
  back_state_t       state_next;
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  row_next;
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  col_next;
  logic [ADDR_W-1:0] offset;
  logic [ADDR_W-1:0] offset_next;
  logic [ADDR_W-1:0] dst;
  logic [ADDR_W-1:0] dst_next;
  logic [CELL_W-1:0] word;
  logic [CELL_W-1:0] word_next;
  logic [CELL_W-1:0] blank;
  logic              out_free;
  logic              emit;
  logic              start_scroll;
  logic              simple_done;

  assign blank = {bg, fg, CH_SPACE};
  assign out_free = !out_valid || out_ready;
  assign init_busy = (state == ST_INIT);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= cells[mem_raddr];
  end

  always_comb begin
    state_next = state;
    row_next = row;
    col_next = col;
    offset_next = offset;
    dst_next = dst;
    word_next = word;
    mem_we = 1'b0;
    mem_waddr = dst;
    mem_wdata = blank;
    mem_raddr = ADDR_W'(op.index);
    op_ready = 1'b0;
    emit = 1'b0;
    start_scroll = 1'b0;
    simple_done = 1'b0;
    case (state)
      ST_INIT: begin
        mem_we = 1'b1;
        mem_wdata = RESET_BLANK;
        if (dst == LAST_CELL) begin
          dst_next = '0;
          state_next = ST_IDLE;
        end else begin
          dst_next = dst + 1'b1;
        end
      end
      ST_IDLE: begin
        if (op_valid) begin
          op_ready = 1'b1;
          word_next = '0;
          case (op.kind)
            OP_CHAR: begin
              mem_we = 1'b1;
              mem_waddr = offset;
              mem_wdata = {bg, fg, op.ch};
              if (col == LAST_COL) begin
                col_next = '0;
                if (row == LAST_ROW) begin
                  start_scroll = 1'b1;
                end else begin
                  row_next = row + 1'b1;
                  offset_next = offset + 1'b1;
                  simple_done = 1'b1;
                end
              end else begin
                col_next = col + 1'b1;
                offset_next = offset + 1'b1;
                simple_done = 1'b1;
              end
            end
            OP_NEWLINE: begin
              col_next = '0;
              if (row == LAST_ROW) begin
                start_scroll = 1'b1;
              end else begin
                row_next = row + 1'b1;
                offset_next = offset - ADDR_W'(col) + ADDR_W'(COLUMNS);
                simple_done = 1'b1;
              end
            end
            OP_RETURN: begin
              col_next = '0;
              offset_next = offset - ADDR_W'(col);
              simple_done = 1'b1;
            end
            OP_BACKSPACE: begin
              if (col != '0) begin
                col_next = col - 1'b1;
                offset_next = offset - 1'b1;
                mem_we = 1'b1;
                mem_waddr = offset - 1'b1;
              end
              simple_done = 1'b1;
            end
            OP_CLEAR: begin
              row_next = '0;
              col_next = '0;
              offset_next = '0;
              dst_next = '0;
              state_next = ST_CLEAR;
            end
            OP_READ: begin
              state_next = ST_READ;
            end
            default: begin
              simple_done = 1'b1;
            end
          endcase
          if (start_scroll) begin
            offset_next = LAST_ROW_BASE;
            dst_next = '0;
            mem_raddr = ADDR_W'(COLUMNS);
            state_next = ST_SCROLL;
          end
          if (simple_done) begin
            if (out_free) begin
              emit = 1'b1;
            end else begin
              state_next = ST_EMIT;
            end
          end
        end
      end
      ST_READ: begin
        word_next = mem_rdata;
        if (out_free) begin
          emit = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (dst == LAST_CELL) begin
          dst_next = '0;
          state_next = ST_EMIT;
        end else begin
          dst_next = dst + 1'b1;
        end
      end
      ST_SCROLL: begin
        mem_we = 1'b1;
        mem_wdata = mem_rdata;
        if (dst == LAST_COPY) begin
          dst_next = LAST_ROW_BASE;
          state_next = ST_BLANK;
        end else begin
          mem_raddr = dst + ADDR_W'(COLUMNS + 1);
          dst_next = dst + 1'b1;
        end
      end
      ST_BLANK: begin
        mem_we = 1'b1;
        if (dst == LAST_CELL) begin
          dst_next = '0;
          state_next = ST_EMIT;
        end else begin
          dst_next = dst + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      row <= '0;
      col <= '0;
      offset <= '0;
      dst <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      row <= row_next;
      col <= col_next;
      offset <= offset_next;
      dst <= dst_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
    if (emit) begin
      cell_word <= word_next;
      cursor_row <= 5'(row_next);
      cursor_col <= 7'(col_next);
      cursor_offset <= 11'(offset_next);
    end
  end

endmodule

[hw/rtl/text_console_writer.sv]
// Channel  Handshake                   Payload
// in       in_valid / in_ready         mode, char_code, cell_index
// out      out_valid / out_ready       cell_word, cursor_row, cursor_col, cursor_offset
// cfg      cfg_write                   cfg_index, cfg_data
//
// After reset the screen memory is swept to blanks, one cell per cycle; no input
// beat is taken during that sweep. Each beat is registered in the two-entry front
// queue. Characters, returns, backspaces and newlines without a scroll are then
// handled in the idle state; a read waits in ST_READ for the registered memory read.
// A clear or a scroll rewrites every cell through the single write port.
// A stalled output holds one result while the next item is already worked on.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS = ROWS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [7:0]         char_code,
  input  logic [INDEX_W-1:0] cell_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CELL_W-1:0]  cell_word,
  output logic [4:0]         cursor_row,
  output logic [6:0]         cursor_col,
  output logic [10:0]        cursor_offset,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_data
);

  logic [3:0] fg;
  logic [3:0] bg;
  logic       op_valid;
  logic       op_ready;
  op_t        op;
  logic       init_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= RESET_FG;
      bg <= RESET_BG;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FOREGROUND: fg <= cfg_data;
        CFG_BACKGROUND: bg <= cfg_data;
        default: fg <= fg;
      endcase
    end
  end

  tcw_front #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .char_code(char_code),
    .cell_index(cell_index),
    .hold(init_busy),
    .op_valid(op_valid),
    .op_ready(op_ready),
    .op(op)
  );

  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .fg(fg),
    .bg(bg),
    .op_valid(op_valid),
    .op_ready(op_ready),
    .op(op),
    .init_busy(init_busy),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cell_word(cell_word),
    .cursor_row(cursor_row),
    .cursor_col(cursor_col),
    .cursor_offset(cursor_offset)
  );

endmodule

[sim/tcw_checker.sv]
`timescale 1ns / 100ps

module tcw_checker import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEFAULT,
  parameter int ROWS = ROWS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [7:0]         char_code,
  input  logic [INDEX_W-1:0] cell_index,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [CELL_W-1:0]  cell_word,
  input  logic [4:0]         cursor_row,
  input  logic [6:0]         cursor_col,
  input  logic [10:0]        cursor_offset,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_data,
  output int                 pending,
  output int                 errors
);

  localparam int CELLS = ROWS * COLUMNS;

  typedef struct packed {
    logic [CELL_W-1:0] word;
    logic [4:0]        row;
    logic [6:0]        col;
    logic [10:0]       offset;
  } cursor_report_t;

  logic [CELL_W-1:0] screen [CELLS];
  int unsigned       cur_row;
  int unsigned       cur_col;
  logic [3:0]        fg_color;
  logic [3:0]        bg_color;
  cursor_report_t    report_q [$];
  int                fail_count;

  function automatic logic [CELL_W-1:0] colored(input logic [7:0] ch);
    return {bg_color, fg_color, ch};
  endfunction

  function automatic void blank_all();
    for (int i = 0; i < CELLS; i++) screen[i] = colored(CH_SPACE);
  endfunction

  function automatic void line_feed();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) screen[i] = colored(CH_SPACE);
      cur_row--;
    end
  endfunction

  function automatic cursor_report_t apply_beat(input logic [1:0] m, input logic [7:0] ch,
                                                input logic [INDEX_W-1:0] idx);
    cursor_report_t r;
    int unsigned    at;
    r = '0;
    case (m)
      MODE_PUT: begin
        at = cur_row * COLUMNS + cur_col;
        if (ch == CH_NEWLINE) begin
          line_feed();
        end else if (ch == CH_RETURN) begin
          cur_col = 0;
        end else if (ch == CH_BACKSPACE) begin
          if (cur_col > 0) begin
            cur_col--;
            screen[at - 1] = colored(CH_SPACE);
          end
        end else begin
          screen[at] = colored(ch);
          cur_col++;
          if (cur_col >= COLUMNS) line_feed();
        end
      end
      MODE_CLEAR: begin
        blank_all();
        cur_row = 0;
        cur_col = 0;
      end
      MODE_READ: begin
        if (idx < CELLS) r.word = screen[idx];
      end
      default: ;
    endcase
    r.row = cur_row[4:0];
    r.col = cur_col[6:0];
    r.offset = 11'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  always @(posedge clk) begin
    cursor_report_t got;
    cursor_report_t want;
    if (rst) begin
      fg_color = RESET_FG;
      bg_color = RESET_BG;
      blank_all();
      cur_row = 0;
      cur_col = 0;
      report_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {cell_word, cursor_row, cursor_col, cursor_offset};
        if (report_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result beat with none expected: word %h row %0d col %0d %s %0d",
                     $time, got.word, got.row, got.col, "offset", got.offset);
        end else begin
          want = report_q.pop_front();
          if (got.word !== want.word || got.row !== want.row || got.col !== want.col ||
              got.offset !== want.offset) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: mismatch: expected word %h row %0d col %0d offset %0d, ",
                        "got word %h row %0d col %0d offset %0d"},
                       $time, want.word, want.row, want.col, want.offset,
                       got.word, got.row, got.col, got.offset);
          end
        end
      end
      if (in_valid && in_ready) report_q.push_back(apply_beat(mode, char_code, cell_index));
      if (cfg_write) begin
        case (cfg_index)
          CFG_FOREGROUND: fg_color = cfg_data;
          CFG_BACKGROUND: bg_color = cfg_data;
          default: ;
        endcase
      end
    end
    pending <= report_q.size();
    errors <= fail_count;
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import tcw_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CELLS = ROWS_DEFAULT * COLUMNS_DEFAULT;
  localparam int SETTLE = CELLS + 100;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BEATS = 160;
  localparam longint LIMIT = 5_000_000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         mode = MODE_PUT;
  logic [7:0]         char_code = 8'h00;
  logic [INDEX_W-1:0] cell_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CELL_W-1:0]  cell_word;
  logic [4:0]         cursor_row;
  logic [6:0]         cursor_col;
  logic [10:0]        cursor_offset;
  logic               cfg_write = 1'b0;
  logic               cfg_index = CFG_FOREGROUND;
  logic [3:0]         cfg_data = 4'h0;

  int     pending;
  int     errors;
  longint cycles = 0;
  bit     calm = 1'b0;
  int     hold_req = 0;
  int     hold_done = 0;
  int     hold_left = 0;
  int     beats_sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  text_console_writer dut (
    .clk, .rst, .in_valid, .in_ready, .mode, .char_code, .cell_index,
    .out_valid, .out_ready, .cell_word, .cursor_row, .cursor_col, .cursor_offset,
    .cfg_write, .cfg_index, .cfg_data
  );

  tcw_checker chk (
    .clk, .rst, .in_valid, .in_ready, .mode, .char_code, .cell_index,
    .out_valid, .out_ready, .cell_word, .cursor_row, .cursor_col, .cursor_offset,
    .cfg_write, .cfg_index, .cfg_data, .pending, .errors
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // The receiver honors a hold-off request by refusing results for a long stretch.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_done + 1;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 27);
    end
  end

  task automatic send_beat(input logic [1:0] m, input logic [7:0] ch,
                           input logic [INDEX_W-1:0] idx);
    if (!calm) begin
      while ($urandom_range(0, 99) < 27) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    mode <= m;
    char_code <= ch;
    cell_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (m != MODE_UNUSED) beats_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg);
    cfg_write <= 1'b1;
    cfg_index <= CFG_FOREGROUND;
    cfg_data <= fg;
    @(posedge clk);
    cfg_index <= CFG_BACKGROUND;
    cfg_data <= bg;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_traffic(input int budget);
    int stop_at;
    int kind;
    int len;
    stop_at = beats_sent + budget;
    while (beats_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(70, 90) : $urandom_range(0, 12);
        repeat (len) begin
          if ($urandom_range(0, 9) == 0)
            send_beat(MODE_PUT, 8'($urandom_range(0, 255)), 11'($urandom));
          else
            send_beat(MODE_PUT, 8'($urandom_range(32, 126)), 11'($urandom));
        end
        case ($urandom_range(0, 6))
          0: ;
          1: begin
            send_beat(MODE_PUT, CH_RETURN, 11'($urandom));
            send_beat(MODE_PUT, CH_NEWLINE, 11'($urandom));
          end
          default: send_beat(MODE_PUT, CH_NEWLINE, 11'($urandom));
        endcase
      end else if (kind < 65) begin
        repeat ($urandom_range(1, 6)) send_beat(MODE_PUT, CH_NEWLINE, 11'($urandom));
      end else if (kind < 75) begin
        repeat ($urandom_range(1, 5)) send_beat(MODE_PUT, CH_BACKSPACE, 11'($urandom));
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 4) == 0)
            send_beat(MODE_READ, 8'($urandom), 11'($urandom_range(CELLS, 2047)));
          else
            send_beat(MODE_READ, 8'($urandom), 11'($urandom_range(0, CELLS - 1)));
        end
      end else if (kind < 94) begin
        send_beat(MODE_PUT, CH_RETURN, 11'($urandom));
      end else if (kind < 97) begin
        send_beat(MODE_UNUSED, 8'($urandom), 11'($urandom));
      end else begin
        send_beat(MODE_CLEAR, 8'($urandom), 11'($urandom));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_beat(MODE_READ, 8'h00, 11'd0);
    send_beat(MODE_READ, 8'hFF, 11'(CELLS - 1));
    send_beat(MODE_READ, 8'h00, 11'(CELLS));
    send_beat(MODE_READ, 8'h00, 11'h7FF);
    send_beat(MODE_PUT, 8'h41, 11'h000);
    send_beat(MODE_PUT, 8'hFF, 11'h7FF);
    send_beat(MODE_PUT, 8'h00, 11'h000);
    send_beat(MODE_READ, 8'h00, 11'd1);
    send_beat(MODE_PUT, CH_BACKSPACE, 11'h000);
    send_beat(MODE_READ, 8'h00, 11'd2);
    send_beat(MODE_PUT, CH_RETURN, 11'h000);
    send_beat(MODE_PUT, CH_BACKSPACE, 11'h000);
    send_beat(MODE_READ, 8'h00, 11'd0);
    send_beat(MODE_PUT, CH_NEWLINE, 11'h000);
    send_beat(MODE_PUT, 8'h7E, 11'h000);
    send_beat(MODE_UNUSED, 8'hFF, 11'h7FF);
    send_beat(MODE_UNUSED, 8'h00, 11'h000);
    send_beat(MODE_READ, 8'h00, 11'(COLUMNS_DEFAULT));
    send_beat(MODE_CLEAR, 8'hFF, 11'h7FF);
    send_beat(MODE_READ, 8'h00, 11'(COLUMNS_DEFAULT));
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_colors(4'hF, 4'hF);
        1: set_colors(4'h0, 4'h0);
        2: set_colors(4'($urandom), 4'($urandom));
        default: set_colors(RESET_FG, RESET_BG);
      endcase
      calm <= (phase == 2);
      run_traffic(20);
      if (phase == 0 || phase == 3) hold_req <= hold_req + 1;
      run_traffic(PHASE_BEATS - 20);
      drain();
    end

    if (errors == 0 && pending == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

[files.f]
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_back.sv
hw/rtl/text_console_writer.sv
sim/tcw_checker.sv
sim/tb_top.sv
